>>> hdl/bdsl_pkg.sv
`timescale 1ns / 1ps

package bdsl_pkg;

  // Configuration register indexes
  localparam int unsigned CfgAddrWidth = 1;
  localparam logic [CfgAddrWidth-1:0] CFG_LONG_PRESS_MS    = 1'b0;
  localparam logic [CfgAddrWidth-1:0] CFG_DEBOUNCE_SAMPLES = 1'b1;
  localparam int unsigned CfgDataWidth = 16;

  // Register reset values
  localparam logic [15:0] LONG_PRESS_MS_RESET    = 16'd3000;
  localparam logic [3:0]  DEBOUNCE_SAMPLES_RESET = 4'd2;

  // Saturation limit of the repeat counter
  localparam logic [3:0] REPEAT_MAX = 4'd15;

  // Stream widths (fields packed from bit 0, padded to whole bytes)
  localparam int unsigned InDataWidth  = 40;
  localparam int unsigned OutDataWidth = 168;

  // One result item
  typedef struct packed {
    logic [31:0] last_change_time;
    logic [31:0] long_press_count;
    logic [31:0] short_press_count;
    logic [31:0] level_change_count;
    logic [31:0] held_ms;
    logic        long_event;
    logic        short_event;
    logic        stable_pressed;
    logic        raw_pressed;
  } result_t;

endpackage

>>> hdl/button_debounce_short_long_press_unit.sv
`timescale 1ns / 1ps

// Push-button debouncer with short and long press detection. Each input item is one
// poll sample (raw active-low pin level, millisecond timestamp) and yields exactly one
// result item with the raw and debounced state, short/long press events, the hold time
// of a completed short press and the wrapping event counters. Throughput is one item per
// clock unless m_axis_tready holds back the result register. Each sample passes through
// the input and result registers, with the compare/subtract state update between them.
// Configuration writes take effect immediately and are meant to be issued while idle.
module button_debounce_short_long_press_unit #(
  parameter int unsigned TIME_WIDTH  = 32,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Input samples
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [0] pin_level, [32:1] now_ms, [39:33] zero
  input  logic [bdsl_pkg::InDataWidth-1:0]       s_axis_tdata,
  // Results
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // [0] raw_pressed, [1] stable_pressed, [2] short_event, [3] long_event,
  // [35:4] held_ms, [67:36] level_change_count, [99:68] short_press_count,
  // [131:100] long_press_count, [163:132] last_change_time, [167:164] zero
  output logic [bdsl_pkg::OutDataWidth-1:0]      m_axis_tdata,
  // Configuration writes
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [bdsl_pkg::CfgAddrWidth-1:0]      cfg_addr_i,
  input  logic [bdsl_pkg::CfgDataWidth-1:0]      cfg_data_i
);

  localparam int unsigned TW = TIME_WIDTH;
  localparam int unsigned CW = COUNT_WIDTH;

  // Configuration registers
  logic [15:0] long_press_ms_q;
  logic [3:0]  debounce_samples_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_ms_q    <= bdsl_pkg::LONG_PRESS_MS_RESET;
      debounce_samples_q <= bdsl_pkg::DEBOUNCE_SAMPLES_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_addr_i)
        bdsl_pkg::CFG_LONG_PRESS_MS:    long_press_ms_q    <= cfg_data_i;
        bdsl_pkg::CFG_DEBOUNCE_SAMPLES: debounce_samples_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic        in_valid_q;
  logic        pin_level_q;
  logic [31:0] now_ms_q;
  logic        advance;
  logic        out_valid_q;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      pin_level_q <= s_axis_tdata[0];
      now_ms_q    <= s_axis_tdata[32:1];
    end
  end

  // Debounce and press state
  logic          stable_q, stable_d;
  logic [3:0]    repeat_q, repeat_d;
  logic [TW-1:0] press_start_q, press_start_d;
  logic          long_done_q, long_done_d;
  logic [CW-1:0] changes_q, changes_d;
  logic [CW-1:0] shorts_q, shorts_d;
  logic [CW-1:0] longs_q, longs_d;
  logic [TW-1:0] last_change_q, last_change_d;

  // Fit timestamp and threshold to the time width
  logic [TW+31:0] now_ext;
  logic [TW+15:0] lp_ext;
  logic [TW-1:0]  now_t;
  logic [TW-1:0]  long_press_t;
  logic [TW-1:0]  elapsed;

  assign now_ext      = {{TW{1'b0}}, now_ms_q};
  assign lp_ext       = {{TW{1'b0}}, long_press_ms_q};
  assign now_t        = now_ext[TW-1:0];
  assign long_press_t = lp_ext[TW-1:0];
  assign elapsed      = now_t - press_start_q;

  logic       raw;
  logic       differ;
  logic [3:0] repeat_inc;
  logic       change;
  logic       short_ev;
  logic       long_ev;

  assign raw        = !pin_level_q;
  assign differ     = raw != stable_q;
  assign repeat_inc = (repeat_q == bdsl_pkg::REPEAT_MAX) ? repeat_q : repeat_q + 4'd1;
  assign change     = differ && (repeat_inc >= debounce_samples_q);
  assign short_ev   = change && !raw && !long_done_q;
  assign long_ev    = !differ && stable_q && !long_done_q && (elapsed >= long_press_t);

  always_comb begin
    stable_d      = stable_q;
    repeat_d      = 4'd0;
    press_start_d = press_start_q;
    long_done_d   = long_done_q;
    changes_d     = changes_q;
    shorts_d      = shorts_q;
    longs_d       = longs_q;
    last_change_d = last_change_q;
    if (differ && !change) begin
      repeat_d = repeat_inc;
    end
    if (change) begin
      stable_d      = raw;
      changes_d     = changes_q + {{(CW-1){1'b0}}, 1'b1};
      last_change_d = now_t;
      if (raw) begin
        press_start_d = now_t;
        long_done_d   = 1'b0;
      end
    end
    if (short_ev) begin
      shorts_d = shorts_q + {{(CW-1){1'b0}}, 1'b1};
    end
    if (long_ev) begin
      long_done_d = 1'b1;
      longs_d     = longs_q + {{(CW-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q      <= 1'b0;
      repeat_q      <= 4'd0;
      press_start_q <= '0;
      long_done_q   <= 1'b0;
      changes_q     <= '0;
      shorts_q      <= '0;
      longs_q       <= '0;
      last_change_q <= '0;
    end else if (advance) begin
      stable_q      <= stable_d;
      repeat_q      <= repeat_d;
      press_start_q <= press_start_d;
      long_done_q   <= long_done_d;
      changes_q     <= changes_d;
      shorts_q      <= shorts_d;
      longs_q       <= longs_d;
      last_change_q <= last_change_d;
    end
  end

  // Fit internal widths to the 32-bit result fields
  logic [TW+31:0] held_ext;
  logic [TW+31:0] last_ext;
  logic [CW+31:0] changes_ext;
  logic [CW+31:0] shorts_ext;
  logic [CW+31:0] longs_ext;

  assign held_ext    = {32'd0, (short_ev ? elapsed : {TW{1'b0}})};
  assign last_ext    = {32'd0, last_change_d};
  assign changes_ext = {32'd0, changes_d};
  assign shorts_ext  = {32'd0, shorts_d};
  assign longs_ext   = {32'd0, longs_d};

  bdsl_pkg::result_t res_d;
  bdsl_pkg::result_t res_q;

  always_comb begin
    res_d.raw_pressed        = raw;
    res_d.stable_pressed     = stable_d;
    res_d.short_event        = short_ev;
    res_d.long_event         = long_ev;
    res_d.held_ms            = held_ext[31:0];
    res_d.level_change_count = changes_ext[31:0];
    res_d.short_press_count  = shorts_ext[31:0];
    res_d.long_press_count   = longs_ext[31:0];
    res_d.last_change_time   = last_ext[31:0];
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, res_q};

  // Checks
  a_events_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.short_event && res_q.long_event))
    else $error("short and long press in the same item");

  a_long_while_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.long_event) |-> res_q.stable_pressed)
    else $error("long press reported while released");

  a_short_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && short_ev) |=> (shorts_q == $past(shorts_q) + {{(CW-1){1'b0}}, 1'b1}))
    else $error("short press not counted");

endmodule

>>> sim/button_debounce_short_long_press_unit_tb.sv
`timescale 1ns / 1ps

module button_debounce_short_long_press_unit_tb;

  // One poll sample as it sits in tdata
  typedef struct packed {
    logic [31:0] now_ms;
    logic        pin_level;
  } poll_t;

  logic                              clk_i         = 1'b0;
  logic                              rst_ni        = 1'b0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  // [0] pin_level, [32:1] now_ms, [39:33] zero
  logic [bdsl_pkg::InDataWidth-1:0]  s_axis_tdata  = '0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  // [0] raw_pressed, [1] stable_pressed, [2] short_event, [3] long_event,
  // [35:4] held_ms, [67:36] level_change_count, [99:68] short_press_count,
  // [131:100] long_press_count, [163:132] last_change_time, [167:164] zero
  logic [bdsl_pkg::OutDataWidth-1:0] m_axis_tdata;
  logic                              cfg_valid_i   = 1'b0;
  logic                              cfg_ready_o;
  logic [bdsl_pkg::CfgAddrWidth-1:0] cfg_addr_i    = bdsl_pkg::CFG_LONG_PRESS_MS;
  logic [bdsl_pkg::CfgDataWidth-1:0] cfg_data_i    = '0;

  button_debounce_short_long_press_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Predicted debouncer registers and state
  logic [15:0] hold_limit   = bdsl_pkg::LONG_PRESS_MS_RESET;
  logic [3:0]  settle_need  = bdsl_pkg::DEBOUNCE_SAMPLES_RESET;
  logic        btn_down     = 1'b0;
  logic [3:0]  settle_cnt   = '0;
  logic [31:0] press_stamp  = '0;
  logic        long_seen    = 1'b0;
  logic [31:0] changes      = '0;
  logic [31:0] shorts       = '0;
  logic [31:0] longs        = '0;
  logic [31:0] change_stamp = '0;

  poll_t             polls_q[$];
  bdsl_pkg::result_t poll_results_q[$];
  int unsigned       errors   = 0;
  logic [31:0]       clock_ms = '0;
  int unsigned       queued   = 0;

  initial forever #10 clk_i = ~clk_i;

  // Advance the predicted debouncer by one accepted sample
  function automatic bdsl_pkg::result_t predict_poll(poll_t p);
    bdsl_pkg::result_t r;
    logic [31:0]       dt;
    r = '0;
    r.raw_pressed = ~p.pin_level;
    dt = p.now_ms - press_stamp;
    if (r.raw_pressed != btn_down) begin
      if (settle_cnt < bdsl_pkg::REPEAT_MAX) settle_cnt++;
      if (settle_cnt >= settle_need) begin
        btn_down     = r.raw_pressed;
        settle_cnt   = '0;
        changes++;
        change_stamp = p.now_ms;
        if (btn_down) begin
          press_stamp = p.now_ms;
          long_seen   = 1'b0;
        end else if (!long_seen) begin
          r.held_ms     = dt;
          r.short_event = 1'b1;
          shorts++;
        end
      end
    end else begin
      settle_cnt = '0;
      if (btn_down && !long_seen && dt >= {16'd0, hold_limit}) begin
        long_seen    = 1'b1;
        r.long_event = 1'b1;
        longs++;
      end
    end
    r.stable_pressed     = btn_down;
    r.level_change_count = changes;
    r.short_press_count  = shorts;
    r.long_press_count   = longs;
    r.last_change_time   = change_stamp;
    return r;
  endfunction

  // Idle length: mostly zero or short, now and then long, with calm runs
  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endfunction

  // Sample driver
  int unsigned tx_gap  = 0;
  int unsigned tx_calm = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        poll_results_q.push_back(predict_poll(s_axis_tdata[32:0]));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (polls_q.size() > 0) begin
          s_axis_tdata  <= {7'd0, polls_q.pop_front()};
          s_axis_tvalid <= 1'b1;
          tx_gap = pick_gap(tx_calm);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure
  int unsigned rx_stall      = 0;
  int unsigned rx_calm       = 0;
  bit          hold_off_done = 1'b0;
  always @(posedge clk_i) begin : result_check
    bdsl_pkg::result_t got;
    bdsl_pkg::result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(bdsl_pkg::result_t)-1:0];
        if (poll_results_q.size() == 0) begin
          errors++;
          $display("%0t: result item with nothing expected, expected none, got %h",
                   $time, got);
        end else begin
          want = poll_results_q.pop_front();
          check_field("raw_pressed", {31'd0, want.raw_pressed}, {31'd0, got.raw_pressed});
          check_field("stable_pressed", {31'd0, want.stable_pressed},
                      {31'd0, got.stable_pressed});
          check_field("short_event", {31'd0, want.short_event}, {31'd0, got.short_event});
          check_field("long_event", {31'd0, want.long_event}, {31'd0, got.long_event});
          check_field("held_ms", want.held_ms, got.held_ms);
          check_field("level_change_count", want.level_change_count,
                      got.level_change_count);
          check_field("short_press_count", want.short_press_count, got.short_press_count);
          check_field("long_press_count", want.long_press_count, got.long_press_count);
          check_field("last_change_time", want.last_change_time, got.last_change_time);
        end
      end
      // one long hold-off while the sender still has plenty queued
      if (!hold_off_done && polls_q.size() > 40) begin
        hold_off_done = 1'b1;
        rx_stall = 300;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        rx_stall = pick_gap(rx_calm);
      end
    end
  end

  task automatic queue_poll(logic pin, logic [31:0] now);
    polls_q.push_back({now, pin});
    queued++;
  endtask

  // Wait until every queued sample is sent and every result is back
  task automatic wait_idle();
    do @(posedge clk_i);
    while (polls_q.size() != 0 || s_axis_tvalid || poll_results_q.size() != 0);
  endtask

  // Write both registers back to back, valid held high across the pair
  task automatic write_cfg(logic [15:0] lp, logic [3:0] dbn);
    cfg_addr_i  <= bdsl_pkg::CFG_LONG_PRESS_MS;
    cfg_data_i  <= lp;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    hold_limit = lp;
    cfg_addr_i <= bdsl_pkg::CFG_DEBOUNCE_SAMPLES;
    cfg_data_i <= {12'd0, dbn};
    do @(posedge clk_i);
    while (!cfg_ready_o);
    settle_need = dbn;
    cfg_valid_i <= 1'b0;
  endtask

  // One press: bouncy edge, steady hold, bouncy release, steady release
  task automatic queue_press(int unsigned hold);
    int unsigned step;
    int unsigned spent;
    int unsigned n;
    int unsigned d;
    int unsigned sn;
    sn = settle_need;
    step = hold / 6 + 1;
    repeat ($urandom_range(0, 3)) begin
      queue_poll(1'($urandom_range(0, 1)), clock_ms);
      clock_ms += $urandom_range(0, 2);
    end
    spent = 0;
    n = 0;
    while (spent < hold || n <= sn) begin
      queue_poll(1'b0, clock_ms);
      d = $urandom_range(1, step);
      clock_ms += d;
      spent += d;
      n++;
    end
    repeat ($urandom_range(0, 3)) begin
      queue_poll(1'($urandom_range(0, 1)), clock_ms);
      clock_ms += $urandom_range(0, 2);
    end
    repeat ($urandom_range(sn + 1, sn + 3)) begin
      queue_poll(1'b1, clock_ms);
      clock_ms += $urandom_range(1, step);
    end
  endtask

  // Mostly well-formed presses around the threshold, some raw noise
  task automatic queue_random(int unsigned count);
    int unsigned r;
    int unsigned hold;
    int unsigned lp;
    lp = hold_limit;
    queued = 0;
    while (queued < count) begin
      r = $urandom_range(0, 99);
      if (r < 5) clock_ms = $urandom();
      if (r < 80) begin
        if (lp == 0) hold = $urandom_range(0, 20);
        else if ($urandom_range(0, 1)) hold = $urandom_range(0, lp - 1);
        else hold = $urandom_range(lp, lp + lp / 2 + 10);
        queue_press(hold);
      end else begin
        repeat ($urandom_range(1, 4)) queue_poll(1'($urandom_range(0, 1)), $urandom());
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed samples at reset settings
    queue_poll(1'b1, 32'h0000_0000);               // same as released state
    queue_poll(1'b0, 32'hFFFF_FFF0);               // first differing sample
    queue_poll(1'b1, 32'hFFFF_FFF1);               // equal again, count cleared
    queue_poll(1'b0, 32'hFFFF_FFF2);
    queue_poll(1'b0, 32'hFFFF_FFF4);               // press accepted
    queue_poll(1'b0, 32'h0000_0010);               // hold across time wrap
    queue_poll(1'b1, 32'h0000_0020);
    queue_poll(1'b1, 32'h0000_0030);               // short press over wrap
    queue_poll(1'b0, 32'h0000_0100);
    queue_poll(1'b0, 32'h0000_0101);
    queue_poll(1'b0, 32'h0000_0101 + 32'd2999);    // just under threshold
    queue_poll(1'b0, 32'h0000_0101 + 32'd3000);    // long press fires
    queue_poll(1'b0, 32'hFFFF_FFFF);               // no second long
    queue_poll(1'b1, 32'hFFFF_FFFF);
    queue_poll(1'b1, 32'h0000_0000);               // release after long
    wait_idle();

    // Zero debounce and zero threshold
    write_cfg(16'd0, 4'd0);
    queue_poll(1'b0, 32'h1234_5678);               // accepted at once
    queue_poll(1'b0, 32'h1234_5678);               // long on first steady sample
    queue_poll(1'b1, 32'h1234_5679);               // release, no short
    queue_poll(1'b0, 32'hAAAA_AAAA);
    queue_poll(1'b1, 32'h5555_5555);               // short press with wrapped hold
    clock_ms = $urandom();
    queue_random(85);
    wait_idle();

    write_cfg(16'd1, 4'd1);
    clock_ms = $urandom();
    queue_random(85);
    wait_idle();

    write_cfg(16'hFFFF, 4'd15);
    clock_ms = 32'hFFFF_0000;
    queue_random(85);
    wait_idle();

    write_cfg(16'd500, 4'd4);
    clock_ms = $urandom();
    queue_random(85);
    wait_idle();

    write_cfg(16'($urandom_range(1, 65535)), 4'($urandom_range(1, 15)));
    clock_ms = $urandom();
    queue_random(85);
    wait_idle();

    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> sim.f
hdl/bdsl_pkg.sv
hdl/button_debounce_short_long_press_unit.sv
sim/button_debounce_short_long_press_unit_tb.sv
